// File: hdl/asf_pkg.sv
// Shared types, constants and register map of the audio slip FIFO.
`default_nettype none
package asf_pkg;

    localparam int DEF_FIFO_DEPTH = 32768;
    localparam int DEF_MAX_BURST  = 32;

    // Frame counts inside one request fit in 7 bits for any burst length up to 64.
    localparam int BCW = 7;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_TARGET_FILL = 2'd0;
    localparam logic [1:0] REG_DEADBAND    = 2'd1;
    localparam logic [1:0] REG_VOLUME      = 2'd2;
    localparam logic [1:0] REG_MUTED       = 2'd3;

    localparam logic [15:0] RST_TARGET_FILL = 16'd1920;
    localparam logic [15:0] RST_DEADBAND    = 16'd480;
    localparam logic [16:0] RST_VOLUME      = 17'd65536;

    // Gains at or above this value play the samples unscaled.
    localparam logic [16:0] VOL_BYPASS = 17'd65471;

    typedef struct packed {
        logic              action;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic              capture_silent;
        logic [5:0]        want;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic              out_silent;
        logic              last;
        logic [31:0]       underrun_total;
        logic [31:0]       overrun_total;
        logic [31:0]       slip_total;
    } t_out_item;

    typedef struct packed {
        logic [15:0] target_fill;
        logic [15:0] deadband;
        logic [16:0] volume;
        logic        muted;
    } t_cfg;

    typedef struct packed {
        logic push;
        logic capture;
        logic decide;
        logic pop;
        logic load;
        logic silent;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic [BCW-1:0] pops;
        logic           dup;
        logic [BCW-1:0] total;
        logic           out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: hdl/asf_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module asf_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [asf_pkg::APB_AW-1:0] paddr,
    input  wire logic [asf_pkg::APB_DW-1:0] pwdata,
    output logic      [asf_pkg::APB_DW-1:0] prdata,
    output logic                           pready,
    output asf_pkg::t_cfg                  o_cfg
);
    import asf_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_fill <= RST_TARGET_FILL;
            r_cfg.deadband    <= RST_DEADBAND;
            r_cfg.volume      <= RST_VOLUME;
            r_cfg.muted       <= 1'b0;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_TARGET_FILL: r_cfg.target_fill <= pwdata[15:0];
                REG_DEADBAND:    r_cfg.deadband    <= pwdata[15:0];
                REG_VOLUME:      r_cfg.volume      <= pwdata[16:0];
                REG_MUTED:       r_cfg.muted       <= pwdata[0];
                default:         r_cfg.muted       <= r_cfg.muted;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TARGET_FILL: prdata = {16'd0, r_cfg.target_fill};
            REG_DEADBAND:    prdata = {16'd0, r_cfg.deadband};
            REG_VOLUME:      prdata = {15'd0, r_cfg.volume};
            REG_MUTED:       prdata = {31'd0, r_cfg.muted};
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/asf_ctrl.sv
// Sequencer for pushes, render decisions and the per-frame output loop.
`default_nettype none
module asf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_action,
    input  wire logic [5:0]        i_want,
    output logic                   o_in_stall,
    output asf_pkg::t_cmd          o_cmd,
    input  wire asf_pkg::t_sts     i_sts
);
    import asf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_FETCH  = 5'b00100,
        S_MUL    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state         r_state, n_state;
    logic [BCW-1:0] r_pops, n_pops;
    logic [BCW-1:0] r_total, n_total;
    logic           r_dup, n_dup;
    logic           r_silent, n_silent;
    logic           r_last, n_last;
    logic           in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state  = r_state;
        n_pops   = r_pops;
        n_total  = r_total;
        n_dup    = r_dup;
        n_silent = r_silent;
        n_last   = r_last;
        o_cmd    = '0;
        o_cmd.silent = r_silent;
        o_cmd.last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_action) begin
                        o_cmd.push = 1'b1;
                    end else if (i_want != 6'd0) begin
                        o_cmd.capture = 1'b1;
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_pops  = i_sts.pops;
                n_dup   = i_sts.dup;
                n_total = i_sts.total;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                // Popped frames come first, then the repeated one, then silence.
                if (r_pops != '0) begin
                    o_cmd.pop = 1'b1;
                    n_pops   = r_pops - BCW'(1);
                    n_silent = 1'b0;
                end else if (r_dup) begin
                    n_dup    = 1'b0;
                    n_silent = 1'b0;
                end else begin
                    n_silent = 1'b1;
                end
                n_last  = (r_total == BCW'(1));
                n_total = r_total - BCW'(1);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = r_last ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pops   <= '0;
            r_total  <= '0;
            r_dup    <= 1'b0;
            r_silent <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pops   <= n_pops;
            r_total  <= n_total;
            r_dup    <= n_dup;
            r_silent <= n_silent;
            r_last   <= n_last;
        end
    end

endmodule
`default_nettype wire

// File: hdl/asf_dp.sv
// Datapath: frame memory, pointers, fill and drift decision, counters, gain and output register.
`default_nettype none
module asf_dp #(
    parameter int FIFO_DEPTH = asf_pkg::DEF_FIFO_DEPTH,
    parameter int MAX_BURST  = asf_pkg::DEF_MAX_BURST
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire asf_pkg::t_in_item i_item,
    input  wire asf_pkg::t_cfg     i_cfg,
    input  wire asf_pkg::t_cmd     i_cmd,
    output asf_pkg::t_sts          o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output asf_pkg::t_out_item     o_out_item
);
    import asf_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = ((CW > 17) ? CW : 17) + 1;

    logic [31:0]    mem [FIFO_DEPTH];
    logic [31:0]    r_rd_data;
    logic signed [33:0] r_prod_l, r_prod_r;

    logic [PW-1:0]  r_rp, r_wp, rp_inc, wp_inc;
    logic [CW-1:0]  r_count;
    logic           r_primed;
    logic [BCW-1:0] r_want;
    logic [31:0]    r_underrun, r_overrun, r_slip;
    logic           r_out_valid;
    t_out_item      r_out;

    logic           full;
    logic [31:0]    push_frame;
    logic [BCW-1:0] want_clamped;

    logic [SW-1:0]  fill_e, tgt_e, db_e, want_e, fill2;
    logic           prime_wait, drop, dup, lt_want, dup_used, empty;
    logic [BCW-1:0] pops, total;
    logic           commit;

    logic           silent, bypass;
    logic [15:0]    left_s, right_s;

    function automatic logic [15:0] round_q16(input logic signed [33:0] p);
        logic signed [17:0] q;
        logic [15:0]        r;
        logic               inc;
        q   = p[33:16];
        r   = p[15:0];
        inc = (r > 16'h8000) || ((r == 16'h8000) && q[0]);
        return q[15:0] + {15'd0, inc};
    endfunction

    assign rp_inc = (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + PW'(1);
    assign wp_inc = (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + PW'(1);
    assign full   = (r_count == CW'(FIFO_DEPTH));
    assign push_frame = i_item.capture_silent ? 32'd0 : {i_item.right_in, i_item.left_in};
    assign want_clamped = ({1'b0, i_item.want} > BCW'(MAX_BURST)) ? BCW'(MAX_BURST)
                                                                   : {1'b0, i_item.want};

    // Drift decision for one render request.
    always_comb begin
        fill_e     = SW'(r_count);
        tgt_e      = SW'(i_cfg.target_fill);
        db_e       = SW'(i_cfg.deadband);
        want_e     = SW'(r_want);
        prime_wait = !r_primed && (fill_e < tgt_e);
        drop       = (fill_e > tgt_e + db_e) && (fill_e > SW'(1));
        dup        = !drop && (fill_e != '0) && (fill_e + db_e < tgt_e);
        fill2      = fill_e - SW'(drop);
        lt_want    = fill2 < want_e;
        empty      = (fill2 == '0);
        dup_used   = !prime_wait && dup && lt_want;
        if (prime_wait) begin
            pops = '0;
        end else if (lt_want) begin
            pops = fill2[BCW-1:0];
        end else begin
            pops = r_want;
        end
        if (prime_wait || empty) begin
            total = r_want;
        end else begin
            total = pops + BCW'(dup_used);
        end
    end

    assign commit = i_cmd.decide && !prime_wait;

    assign o_sts.pops     = pops;
    assign o_sts.dup      = dup_used;
    assign o_sts.total    = total;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_wp] <= push_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_rd_data <= mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_l <= 34'($signed(r_rd_data[15:0]) * $signed({1'b0, i_cfg.volume}));
        r_prod_r <= 34'($signed(r_rd_data[31:16]) * $signed({1'b0, i_cfg.volume}));
        if (i_cmd.capture) begin
            r_want <= want_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp       <= '0;
            r_wp       <= '0;
            r_count    <= '0;
            r_primed   <= 1'b0;
            r_underrun <= '0;
            r_overrun  <= '0;
            r_slip     <= '0;
        end else begin
            if (i_cmd.push) begin
                r_wp <= wp_inc;
                if (full) begin
                    r_rp      <= rp_inc;
                    r_overrun <= r_overrun + 32'd1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (commit) begin
                r_primed <= 1'b1;
                r_slip   <= r_slip + 32'(drop) + 32'(dup_used);
                if (empty) begin
                    r_underrun <= r_underrun + 32'(r_want);
                end
                if (drop) begin
                    r_rp    <= rp_inc;
                    r_count <= r_count - CW'(1);
                end
            end
            if (i_cmd.pop) begin
                r_rp    <= rp_inc;
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign silent  = i_cmd.silent || i_cfg.muted;
    assign bypass  = (i_cfg.volume >= VOL_BYPASS);
    assign left_s  = bypass ? r_rd_data[15:0]  : round_q16(r_prod_l);
    assign right_s = bypass ? r_rd_data[31:16] : round_q16(r_prod_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.left_out       <= silent ? 16'sd0 : $signed(left_s);
            r_out.right_out      <= silent ? 16'sd0 : $signed(right_s);
            r_out.out_silent     <= silent;
            r_out.last           <= i_cmd.last;
            r_out.underrun_total <= r_underrun;
            r_out.overrun_total  <= r_overrun;
            r_out.slip_total     <= r_slip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// File: hdl/audio_slip_fifo_top.sv
// Top level of the audio slip FIFO: registers, sequencer and datapath.
// Input channel: each item is either a push of one captured stereo frame
// (action 0) or a render request for up to MAX_BURST frames (action 1).
// A push writes the frame memory directly; it gives no result. A render
// request first makes the drift decision (priming, drop or repeat,
// underrun), then walks each of its frames in turn through memory read,
// gain multiply and rounding. While a request is being rendered the
// input channel is stalled; the final frame of a burst carries last,
// and all frames of one burst show the counter totals as they stand
// after that request.
// Output channel: results sit in an output register. When the receiver
// stalls, the frame loop waits at the rounding step and nothing is lost;
// the next input item is accepted while the last frame still waits.
// A request with want zero is accepted and has no effect.
// Reset clears pointers, fill, priming and counters and restores the
// register defaults. The frame memory is not cleared; only written entries
// are ever read. Configuration is written through the APB-style port.
`default_nettype none
module audio_slip_fifo_top #(
    parameter int FIFO_DEPTH = asf_pkg::DEF_FIFO_DEPTH,
    parameter int MAX_BURST  = asf_pkg::DEF_MAX_BURST
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [asf_pkg::APB_AW-1:0] paddr,
    input  wire logic [asf_pkg::APB_DW-1:0] pwdata,
    output logic      [asf_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire asf_pkg::t_in_item          i_in_item,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output asf_pkg::t_out_item              o_out_item
);
    import asf_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // Register file holding target fill, deadband, volume and mute.
    asf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The sequencer only looks at the action and the size of the request.
    asf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_item.action),
        .i_want     (i_in_item.want),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // The datapath owns the frame memory, fill state, counters and output register.
    asf_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .MAX_BURST  (MAX_BURST)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the audio slip FIFO with a frame-accurate predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import asf_pkg::*;

    // Generous cycle budget: several times the slowest correct run, even with
    // full bursts and the longest receiver stalls on every frame.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles allowed for a push still in flight after the last frame has left.
    localparam int SETTLE_CYCLES = 16;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_OFF_CYCLES = 300;

    // Tracks the ring, the drift controller and the counters, and keeps the
    // rendered frames still owed by the block in order of arrival.
    class slip_tracker;
        bit [31:0]  ring [DEF_FIFO_DEPTH];
        int         rd_ptr;
        int         fill_count;
        bit         primed;
        bit [31:0]  underruns;
        bit [31:0]  overruns;
        bit [31:0]  slips;
        t_cfg       regs;
        t_out_item  frames_due [$];
        int         mismatches;

        function new();
            regs.target_fill = RST_TARGET_FILL;
            regs.deadband    = RST_DEADBAND;
            regs.volume      = RST_VOLUME;
            regs.muted       = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_TARGET_FILL: regs.target_fill = value[15:0];
                REG_DEADBAND:    regs.deadband    = value[15:0];
                REG_VOLUME:      regs.volume      = value[16:0];
                REG_MUTED:       regs.muted       = value[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return frames_due.size();
        endfunction

        // Gain in units of 1/65536, rounded to nearest with ties to even.
        function bit [15:0] apply_gain(bit [15:0] s);
            longint p, a, q, r;
            if (regs.volume >= VOL_BYPASS) return s;
            p = longint'($signed(s)) * longint'(regs.volume);
            a = (p < 0) ? -p : p;
            q = a >> 16;
            r = a & 64'hFFFF;
            if (r > 64'h8000 || (r == 64'h8000 && q[0])) q = q + 1;
            if (p < 0) q = -q;
            return q[15:0];
        endfunction

        function void store_frame(t_in_item it);
            bit [31:0] f;
            f = it.capture_silent ? 32'd0 : {it.right_in, it.left_in};
            if (fill_count >= DEF_FIFO_DEPTH) begin
                // Ring full: the oldest frame makes room.
                rd_ptr = (rd_ptr + 1) % DEF_FIFO_DEPTH;
                fill_count--;
                overruns++;
            end
            ring[(rd_ptr + fill_count) % DEF_FIFO_DEPTH] = f;
            fill_count++;
        endfunction

        function void render_request(t_in_item it);
            bit [31:0] burst [DEF_MAX_BURST];
            bit        hush [DEF_MAX_BURST];
            int        n_want, fill, n_out, n_pop, done, tgt, band;
            bit        dup_frame;
            t_out_item f;
            n_want = (it.want > DEF_MAX_BURST) ? DEF_MAX_BURST : int'(it.want);
            if (n_want == 0) return;
            tgt = int'(regs.target_fill);
            band = int'(regs.deadband);
            dup_frame = 1'b0;
            for (int k = 0; k < n_want; k++) begin
                burst[k] = 32'd0;
                hush[k] = 1'b1;
            end
            fill = fill_count;
            if (!primed && fill < tgt) begin
                n_out = n_want;
            end else begin
                primed = 1'b1;
                if (fill > tgt + band && fill > 1) begin
                    rd_ptr = (rd_ptr + 1) % DEF_FIFO_DEPTH;
                    fill_count--;
                    fill--;
                    slips++;
                end else if (fill > 0 && fill + band < tgt) begin
                    dup_frame = 1'b1;
                end
                n_out = fill + int'(dup_frame);
                if (n_out > n_want) n_out = n_want;
                if (n_out == 0) begin
                    n_out = n_want;
                    underruns += n_want;
                end else begin
                    n_pop = (n_out < fill) ? n_out : fill;
                    for (done = 0; done < n_pop; done++) begin
                        burst[done] = ring[rd_ptr];
                        hush[done] = 1'b0;
                        rd_ptr = (rd_ptr + 1) % DEF_FIFO_DEPTH;
                        fill_count--;
                    end
                    if (dup_frame && done > 0 && done < n_out) begin
                        burst[done] = burst[done - 1];
                        hush[done] = 1'b0;
                        done++;
                        slips++;
                    end
                    underruns += n_out - done;
                    for (int k = 0; k < n_out; k++) begin
                        if (regs.muted) begin
                            hush[k] = 1'b1;
                        end else if (!hush[k]) begin
                            burst[k] = {apply_gain(burst[k][31:16]), apply_gain(burst[k][15:0])};
                        end
                    end
                end
            end
            // Every frame of the burst shows the totals after the whole request.
            for (int k = 0; k < n_out; k++) begin
                f.left_out       = hush[k] ? 16'd0 : burst[k][15:0];
                f.right_out      = hush[k] ? 16'd0 : burst[k][31:16];
                f.out_silent     = hush[k];
                f.last           = (k == n_out - 1);
                f.underrun_total = underruns;
                f.overrun_total  = overruns;
                f.slip_total     = slips;
                frames_due.push_back(f);
            end
        endfunction

        function void accept_item(t_in_item it);
            if (it.action) render_request(it);
            else store_frame(it);
        endfunction

        function string describe(t_out_item f);
            return $sformatf("L=%0d R=%0d silent=%0b last=%0b under=%0d over=%0d slip=%0d",
                             f.left_out, f.right_out, f.out_silent, f.last,
                             f.underrun_total, f.overrun_total, f.slip_total);
        endfunction

        function void check_frame(t_out_item got);
            t_out_item exp_f;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected frame: %s", describe(got));
                return;
            end
            exp_f = frames_due.pop_front();
            if (got.left_out !== exp_f.left_out || got.right_out !== exp_f.right_out ||
                got.out_silent !== exp_f.out_silent || got.last !== exp_f.last ||
                got.underrun_total !== exp_f.underrun_total ||
                got.overrun_total !== exp_f.overrun_total ||
                got.slip_total !== exp_f.slip_total) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("frame mismatch: expected %s", describe(exp_f));
                    $display("                got      %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;

    slip_tracker tracker = new();

    // Random idling on both channels is enabled while this is set.
    bit idle_on = 1'b0;
    // Receiver hold-off in cycles, requested by the stimulus process.
    int hold_cycles = 0;
    int stall_run = 0;
    int cycle_count = 0;

    audio_slip_fifo_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // The watchdog ends a run that hangs. Its count starts with the clock.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Every frame that crosses the output handshake is checked against the
    // oldest frame still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_frame(o_out_item);
    end

    // Receiver side. A requested hold-off takes priority and is counted down
    // here; otherwise stalls come in random bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else if (stall_run > 0) begin
            i_out_stall <= 1'b1;
            stall_run = stall_run - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_run = $urandom_range(0, 4);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic t_in_item push_of(logic [15:0] l, logic [15:0] r, logic hush);
        t_in_item it;
        it.action         = 1'b0;
        it.left_in        = l;
        it.right_in       = r;
        it.capture_silent = hush;
        it.want           = 6'($urandom_range(0, 63));
        return it;
    endfunction

    // The sample fields of a render request are ignored, so they carry noise.
    function automatic t_in_item render_of(int n);
        t_in_item it;
        it.action         = 1'b1;
        it.left_in        = 16'($urandom);
        it.right_in       = 16'($urandom);
        it.capture_silent = 1'($urandom_range(0, 1));
        it.want           = 6'(n);
        return it;
    endfunction

    // Offers one item and returns at the edge where it is taken. With idling
    // on, a random gap with valid low may come first. Back-to-back items keep
    // valid high across the boundary.
    task automatic send_item(t_in_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 5)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        tracker.accept_item(it);
    endtask

    // Drops valid and waits until every owed frame has come back. A push may
    // still be in flight when the last frame leaves, so a short settle follows.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [31:0] tgt, logic [31:0] band, logic [31:0] gain,
                             logic [31:0] mute);
        wait_idle();
        write_reg(REG_TARGET_FILL, tgt);
        write_reg(REG_DEADBAND, band);
        write_reg(REG_VOLUME, gain);
        write_reg(REG_MUTED, mute);
    endtask

    // Mostly well-formed traffic: a short run of pushes followed by a render
    // request sized near that run, so the fill hovers around small targets
    // and the drop, repeat and underrun paths all get hit. The rest is noise
    // with every field random. Requests for zero frames are not counted.
    task automatic run_traffic(int n_items);
        int sent, k, n;
        t_in_item it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(1, 10);
                repeat (k) send_item(push_of(16'($urandom), 16'($urandom),
                                             $urandom_range(0, 7) == 0));
                n = k - 2 + int'($urandom_range(0, 4));
                if (n < 1) n = 1;
                send_item(render_of(n));
                sent += k + 1;
            end else begin
                it.action         = 1'($urandom_range(0, 1));
                it.left_in        = 16'($urandom);
                it.right_in       = 16'($urandom);
                it.capture_silent = 1'($urandom_range(0, 1));
                it.want           = 6'($urandom_range(0, 63));
                send_item(it);
                if (!(it.action && it.want == 0)) sent++;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        // With the reset target of 1920 frames the block is still priming:
        // an empty request does nothing, an oversized one is clipped to the
        // burst limit, and everything plays as silence.
        send_item(render_of(0));
        send_item(render_of(40));
        send_item(push_of(16'h1234, 16'hFEDC, 1'b0));
        send_item(push_of(16'h7FFF, 16'h8000, 1'b0));
        send_item(push_of(16'h0001, 16'hFFFF, 1'b0));
        send_item(render_of(2));

        // Small target so priming completes, then walk through the extremes
        // of the samples, a silent capture, a drop, an oversized burst cut short
        // to the frames on hand, a pure underrun and the repeat of the last frame.
        configure(32'd4, 32'd1, 32'd65536, 32'd0);
        send_item(push_of(16'h8000, 16'h7FFF, 1'b0));
        send_item(push_of(16'h7FFF, 16'h8000, 1'b0));
        send_item(push_of(16'h7FFF, 16'h8000, 1'b1));
        send_item(push_of(16'h0000, 16'hFFFF, 1'b0));
        send_item(push_of(16'h5555, 16'hAAAA, 1'b0));
        send_item(render_of(1));
        send_item(render_of(63));
        send_item(render_of(3));
        send_item(push_of(16'hFFFF, 16'h0000, 1'b0));
        send_item(push_of(16'hAAAA, 16'h5555, 1'b0));
        send_item(render_of(5));
        send_item(push_of(16'h0F0F, 16'hF0F0, 1'b0));
        send_item(render_of(1));
        send_item(render_of(32));

        // Long receiver hold-off while the sender keeps offering items, so
        // the block backs up and stalls its input.
        configure(32'd8, 32'd2, 32'd65536, 32'd0);
        @(posedge i_clk);
        hold_cycles = HOLD_OFF_CYCLES;
        run_traffic(30);

        // Zero gain and zero target: every render drops when it can.
        configure(32'd0, 32'd0, 32'd0, 32'd0);
        run_traffic(20);

        // Half gain puts odd samples exactly on a rounding tie.
        configure(32'd16, 32'd4, 32'd32768, 32'd0);
        send_item(push_of(16'h0001, 16'hFFFF, 1'b0));
        send_item(push_of(16'h0003, 16'hFFFD, 1'b0));
        send_item(push_of(16'h8000, 16'h7FFF, 1'b0));
        send_item(render_of(3));
        run_traffic(20);

        // All-ones writes: upper bits are dropped, giving maximum target,
        // band and gain, and mute.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_traffic(20);

        // Both sides of the bypass threshold of the gain.
        configure(32'd6, 32'd0, 32'd65470, 32'd0);
        run_traffic(20);
        configure(32'd4, 32'd1, 32'd65471, 32'd0);
        run_traffic(20);

        configure($urandom_range(0, 40), $urandom_range(0, 8), $urandom_range(0, 131071),
                  $urandom_range(0, 1));
        run_traffic(20);

        // Final stretch without idling: refill to around the target, then
        // render full bursts with a little refill in between, so the ring
        // drains into repeats and silent underrun bursts.
        configure(32'd24, 32'd4, 32'd40000, 32'd0);
        idle_on = 1'b0;
        repeat (24) send_item(push_of(16'($urandom), 16'($urandom), 1'b0));
        repeat (4) begin
            send_item(render_of($urandom_range(24, 40)));
            repeat ($urandom_range(0, 3)) send_item(push_of(16'($urandom), 16'($urandom), 1'b0));
        end

        // Drain, then leave room for any stray frame before the verdict.
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/asf_pkg.sv
hdl/asf_regs.sv
hdl/asf_ctrl.sv
hdl/asf_dp.sv
hdl/audio_slip_fifo_top.sv
sim/testbench.sv
